### rtl/ort_pkg.sv
// Shared widths, codes and types of the outstanding request tracker.
package ort_pkg;

    localparam int OP_W       = 2;
    localparam int SLOT_W     = 6;
    localparam int NF_W       = 6;
    localparam int LUN_W      = 2;
    localparam int CMD_W      = 8;
    localparam int FIELDS_W   = NF_W + LUN_W + LUN_W + CMD_W;
    localparam int GRP_SIZE   = 8;
    localparam int GRP_IDX_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_MATCH   = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } scan_res_t;

endpackage

### rtl/ort_if.sv
// Request and response channels of the outstanding request tracker.
interface ort_req_if;
    import ort_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  req_type;
    logic [SLOT_W-1:0] slot;
    logic [NF_W-1:0]  net_fn;
    logic [LUN_W-1:0] requester_lun;
    logic [LUN_W-1:0] responder_lun;
    logic [CMD_W-1:0] command;

    modport source (
        output valid, req_type, slot, net_fn, requester_lun, responder_lun, command,
        input  ready
    );
    modport sink (
        input  valid, req_type, slot, net_fn, requester_lun, responder_lun, command,
        output ready
    );
endinterface

interface ort_rsp_if;
    import ort_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [SLOT_W-1:0] slot_out;
    logic              was_matched;

    modport source (
        output valid, status, slot_out, was_matched,
        input  ready
    );
    modport sink (
        input  valid, status, slot_out, was_matched,
        output ready
    );
endinterface

### rtl/ort_free_scan.sv
// Two-stage round-robin free-slot search over the slot valid bits.
module ort_free_scan #(
    parameter int SLOTS = 64
) (
    input  logic                       clk,
    input  logic                       load,
    input  logic [SLOTS-1:0]           valid_vec,
    input  logic [$clog2(SLOTS)-1:0]   last_seq,
    output ort_pkg::scan_res_t         res
);
    import ort_pkg::*;

    localparam int GROUPS = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD    = GROUPS * GRP_SIZE;

    logic [PAD-1:0]       free_pad;
    logic [PAD-1:0]       above;
    logic [GROUPS-1:0]    hi_any;
    logic [GROUPS-1:0]    all_any;
    logic [GRP_IDX_W-1:0] hi_idx [GROUPS];
    logic [GRP_IDX_W-1:0] all_idx [GROUPS];

    logic [GROUPS-1:0]    hi_any_reg;
    logic [GROUPS-1:0]    all_any_reg;
    logic [GRP_IDX_W-1:0] hi_idx_reg [GROUPS];
    logic [GRP_IDX_W-1:0] all_idx_reg [GROUPS];

    logic                 hi_found;
    logic                 all_found;
    logic [SLOT_W-1:0]    hi_pos;
    logic [SLOT_W-1:0]    all_pos;

    // stage 1: lowest free slot per group, both past last_seq and anywhere
    always_comb
    begin
        free_pad = '0;
        free_pad[SLOTS-1:0] = ~valid_vec;
        for (int i = 0; i < PAD; i++)
        begin
            above[i] = (i > int'(last_seq));
        end
        for (int g = 0; g < GROUPS; g++)
        begin
            hi_any[g]  = 1'b0;
            all_any[g] = 1'b0;
            hi_idx[g]  = '0;
            all_idx[g] = '0;
            for (int j = GRP_SIZE - 1; j >= 0; j--)
            begin
                if (free_pad[g*GRP_SIZE + j] && above[g*GRP_SIZE + j])
                begin
                    hi_any[g] = 1'b1;
                    hi_idx[g] = GRP_IDX_W'(j);
                end
                if (free_pad[g*GRP_SIZE + j])
                begin
                    all_any[g] = 1'b1;
                    all_idx[g] = GRP_IDX_W'(j);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hi_any_reg  <= hi_any;
            all_any_reg <= all_any;
            hi_idx_reg  <= hi_idx;
            all_idx_reg <= all_idx;
        end
    end

    // stage 2: first group wins; wrap to the overall lowest when nothing is above
    always_comb
    begin
        hi_found  = 1'b0;
        all_found = 1'b0;
        hi_pos    = '0;
        all_pos   = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (hi_any_reg[g])
            begin
                hi_found = 1'b1;
                hi_pos   = SLOT_W'(g * GRP_SIZE) + SLOT_W'(hi_idx_reg[g]);
            end
            if (all_any_reg[g])
            begin
                all_found = 1'b1;
                all_pos   = SLOT_W'(g * GRP_SIZE) + SLOT_W'(all_idx_reg[g]);
            end
        end
        res.found = hi_found || all_found;
        res.idx   = hi_found ? hi_pos : all_pos;
    end

endmodule

### rtl/outstanding_request_tracker.sv
// Outstanding request tracker: sequence-number slot table for IPMB request/response matching.
//
// Each request word is one of three operations. Allocate takes the first free slot
// after the last one granted (round-robin, wrapping), stores the request's netFn,
// both LUNs and command, and returns the slot; status 1 means all slots are busy.
// Match checks a response against a valid slot: the response netFn must equal the
// stored netFn plus one, with equal LUNs and command; the slot is then flagged
// matched. Release frees a valid slot and returns whether it had been matched.
// Out-of-range slots, invalid slots and unknown operations answer status 1 and
// change nothing. Every request word yields exactly one response word.
// Timing: one operation at a time. The response register loads from the state
// register entered at acceptance, and the next request can be taken once it has
// loaded, even if the response has not been drained. An operation takes longer
// only while the response register still holds an earlier word the sink has not
// taken. The state register between acceptance and result covers the registered
// two-level free-slot search for allocate and the registered read of the slot
// field memory for match. Valid and matched flags live in flip-flops cleared by
// reset, so no clearing pass is needed; the field memory is only read behind a
// valid flag.
module outstanding_request_tracker #(
    parameter int SLOTS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    ort_req_if.sink   req,
    ort_rsp_if.source rsp
);
    import ort_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    // control
    state_t            state_reg;
    state_t            state_next;
    logic              accept;
    logic              out_free;
    logic              fin;

    // latched request word
    op_t               op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [NF_W-1:0]   nf_reg;
    logic [LUN_W-1:0]  rq_reg;
    logic [LUN_W-1:0]  rs_reg;
    logic [CMD_W-1:0]  cmd_reg;

    // slot state
    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  valid_next;
    logic [SLOTS-1:0]  matched_reg;
    logic [SLOTS-1:0]  matched_next;
    logic [IDX_W-1:0]  last_seq_reg;
    logic [IDX_W-1:0]  last_seq_next;
    logic [FIELDS_W-1:0] fields_mem [SLOTS];
    logic [FIELDS_W-1:0] rdata_reg;

    // search and decode
    scan_res_t         scan_res;
    logic [IDX_W-1:0]  pick_idx;
    logic [IDX_W-1:0]  sidx;
    logic              in_range;
    logic              slot_hit;
    logic              fields_eq;
    logic              alloc_commit;
    logic              match_commit;
    logic              release_commit;

    // result
    logic              res_status;
    logic [SLOT_W-1:0] res_slot;
    logic              res_was;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_was_reg;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot_out    = out_slot_reg;
    assign rsp.was_matched = out_was_reg;

    ort_free_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .clk       (clk),
        .load      (accept),
        .valid_vec (valid_reg),
        .last_seq  (last_seq_reg),
        .res       (scan_res)
    );

    assign pick_idx = scan_res.idx[IDX_W-1:0];
    assign sidx     = slot_reg[IDX_W-1:0];
    assign in_range = ({1'b0, slot_reg} < (SLOT_W + 1)'(SLOTS));
    assign slot_hit = in_range && valid_reg[sidx];

    // netFn compare in 7 bits: a stored 63 never matches
    assign fields_eq = (({1'b0, rdata_reg[FIELDS_W-1 -: NF_W]} + (NF_W + 1)'(1))
                            == {1'b0, nf_reg})
                    && (rdata_reg[CMD_W + 2*LUN_W - 1 -: LUN_W] == rq_reg)
                    && (rdata_reg[CMD_W + LUN_W - 1 -: LUN_W] == rs_reg)
                    && (rdata_reg[CMD_W-1:0] == cmd_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op_t'(req.req_type) == OP_ALLOC) ? ST_PICK : ST_EXEC;
                end
            end
            ST_PICK, ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // per-state outputs: result word and table commits
    always_comb
    begin
        fin            = 1'b0;
        res_status     = 1'b1;
        res_slot       = '0;
        res_was        = 1'b0;
        alloc_commit   = 1'b0;
        match_commit   = 1'b0;
        release_commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                fin = 1'b0;
            end
            ST_PICK:
            begin
                fin = out_free;
                if (scan_res.found)
                begin
                    res_status   = 1'b0;
                    res_slot     = scan_res.idx;
                    alloc_commit = out_free;
                end
            end
            ST_EXEC:
            begin
                fin = out_free;
                case (op_reg)
                    OP_MATCH:
                    begin
                        if (slot_hit && fields_eq)
                        begin
                            res_status   = 1'b0;
                            res_slot     = slot_reg;
                            match_commit = out_free;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (slot_hit)
                        begin
                            res_status     = 1'b0;
                            res_slot       = slot_reg;
                            res_was        = matched_reg[sidx];
                            release_commit = out_free;
                        end
                    end
                    default:
                    begin
                        res_status = 1'b1;
                    end
                endcase
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    // flag and pointer updates
    always_comb
    begin
        valid_next    = valid_reg;
        matched_next  = matched_reg;
        last_seq_next = last_seq_reg;
        if (alloc_commit)
        begin
            valid_next[pick_idx]   = 1'b1;
            matched_next[pick_idx] = 1'b0;
            last_seq_next          = pick_idx;
        end
        if (match_commit)
        begin
            matched_next[sidx] = 1'b1;
        end
        if (release_commit)
        begin
            valid_next[sidx]   = 1'b0;
            matched_next[sidx] = 1'b0;
        end
        if (fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            matched_reg   <= '0;
            last_seq_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            matched_reg   <= matched_next;
            last_seq_reg  <= last_seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(req.req_type);
            slot_reg <= req.slot;
            nf_reg   <= req.net_fn;
            rq_reg   <= req.requester_lun;
            rs_reg   <= req.responder_lun;
            cmd_reg  <= req.command;
        end
        if (fin)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_was_reg    <= res_was;
        end
    end

    // slot field memory: written on grant, read at acceptance for match
    always_ff @(posedge clk)
    begin
        if (alloc_commit)
        begin
            fields_mem[pick_idx] <= {nf_reg, rq_reg, rs_reg, cmd_reg};
        end
        if (accept)
        begin
            rdata_reg <= fields_mem[req.slot[IDX_W-1:0]];
        end
    end

    // the search never hands out a slot that is in use
    a_pick_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK && scan_res.found) |-> !valid_reg[pick_idx])
        else $error("free-slot search returned a valid slot");

    // a grant leaves last_seq on a fresh, unmatched slot
    a_grant_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_commit |=> (valid_reg[last_seq_reg] && !matched_reg[last_seq_reg]))
        else $error("granted slot not valid or still matched");

    // matched flag only on outstanding slots
    a_matched_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (matched_reg & ~valid_reg) == '0)
        else $error("matched flag set on a free slot");

    // one operation in flight at a time
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("request taken without leaving idle");

endmodule

### tb/ort_checker.sv
// Scoreboard for the outstanding request tracker: mirrors the slot table and checks each response word.
module ort_checker #(
    parameter int SLOTS = 64
) (
    input  logic clk,
    input  logic rst_n,
    ort_req_if   req,
    ort_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding,
    output int   n_granted,
    output int   n_full,
    output int   n_matched,
    output int   n_released,
    output int   n_released_hit,
    output int   n_refused
);
    timeunit 1ns;
    timeprecision 1ps;

    import ort_pkg::*;

    typedef struct packed {
        logic [NF_W-1:0]  net_fn;
        logic [LUN_W-1:0] rq_lun;
        logic [LUN_W-1:0] rs_lun;
        logic [CMD_W-1:0] command;
    } req_tag_t;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot_out;
        logic              was_matched;
    } outcome_t;

    // mirror of the slot table
    logic              live [SLOTS];
    logic              hit  [SLOTS];
    req_tag_t          tag  [SLOTS];
    logic [SLOT_W-1:0] last_grant;

    outcome_t due_q[$];

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("%0t ns mismatch, %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Applies one request word to the mirror and returns the response it must produce.
    function automatic outcome_t resolve_word(logic [OP_W-1:0] kind, logic [SLOT_W-1:0] s,
                                              req_tag_t t);
        outcome_t      r;
        int            cand;
        logic          done;
        logic [NF_W:0] reply_nf;
        r.status      = 1'b1;
        r.slot_out    = '0;
        r.was_matched = 1'b0;
        done          = 1'b0;
        case (kind)
            OP_ALLOC:
            begin
                // round-robin search, starting one past the last grant
                cand = int'(last_grant);
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done)
                    begin
                        cand = (cand + 1 >= SLOTS) ? 0 : cand + 1;
                        if (!live[cand])
                        begin
                            live[cand] = 1'b1;
                            hit[cand]  = 1'b0;
                            tag[cand]  = t;
                            last_grant = SLOT_W'(cand);
                            r.status   = 1'b0;
                            r.slot_out = SLOT_W'(cand);
                            done       = 1'b1;
                        end
                    end
                end
                if (done)
                    n_granted++;
                else
                    n_full++;
            end
            OP_MATCH:
            begin
                if (int'(s) < SLOTS && live[s])
                begin
                    // 7-bit compare: a stored netFn of 63 can never be answered
                    reply_nf = {1'b0, tag[s].net_fn} + 1'b1;
                    if (reply_nf == {1'b0, t.net_fn} && tag[s].rq_lun == t.rq_lun &&
                        tag[s].rs_lun == t.rs_lun && tag[s].command == t.command)
                    begin
                        hit[s]     = 1'b1;
                        r.status   = 1'b0;
                        r.slot_out = s;
                    end
                end
                if (r.status)
                    n_refused++;
                else
                    n_matched++;
            end
            OP_RELEASE:
            begin
                if (int'(s) < SLOTS && live[s])
                begin
                    r.was_matched = hit[s];
                    live[s]       = 1'b0;
                    hit[s]        = 1'b0;
                    r.status      = 1'b0;
                    r.slot_out    = s;
                    n_released++;
                    if (r.was_matched)
                        n_released_hit++;
                end
                else
                begin
                    n_refused++;
                end
            end
            default:
            begin
                n_refused++;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        req_tag_t t;
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                live[i] = 1'b0;
                hit[i]  = 1'b0;
            end
            last_grant     = '0;
            due_q.delete();
            mismatches     = 0;
            outstanding    = 0;
            n_granted      = 0;
            n_full         = 0;
            n_matched      = 0;
            n_released     = 0;
            n_released_hit = 0;
            n_refused      = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_q.size() == 0)
                begin
                    report_mismatch("response word with nothing expected, slot_out",
                                    8'(rsp.slot_out), 8'd0);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 8'(rsp.status), 8'(want.status));
                    if (rsp.slot_out !== want.slot_out)
                        report_mismatch("slot_out", 8'(rsp.slot_out), 8'(want.slot_out));
                    if (rsp.was_matched !== want.was_matched)
                        report_mismatch("was_matched", 8'(rsp.was_matched),
                                        8'(want.was_matched));
                end
            end
            if (req.valid && req.ready)
            begin
                t.net_fn  = req.net_fn;
                t.rq_lun  = req.requester_lun;
                t.rs_lun  = req.responder_lun;
                t.command = req.command;
                due_q.push_back(resolve_word(req.req_type, req.slot, t));
            end
            outstanding = due_q.size();
        end
    end

endmodule

### tb/tb_top.sv
// Testbench top of the outstanding request tracker: stimulus, receiver stalls, watchdog and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ort_pkg::*;

    localparam int SLOTS        = 64;
    localparam int RANDOM_WORDS = 1800;
    localparam int HOLD_AT      = 600;    // random word index where the long hold-off starts
    localparam int HOLD_CYCLES  = 300;    // receiver stays low this long
    localparam int IDLE_LIMIT   = 2000;   // cycles with no handshake at all before giving up
    localparam int DRAIN_CYCLES = 20;     // extra wait after the scoreboard has no word left pending

    // req_type 3 has no meaning; the block must refuse it
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } traffic_t;

    typedef struct packed {
        logic [OP_W-1:0]   kind;
        logic [SLOT_W-1:0] slot;
        logic [NF_W-1:0]   net_fn;
        logic [LUN_W-1:0]  rq_lun;
        logic [LUN_W-1:0]  rs_lun;
        logic [CMD_W-1:0]  command;
    } word_t;

    logic clk;
    logic rst_n;

    ort_req_if req_ch ();
    ort_rsp_if rsp_ch ();

    int mismatches;
    int pending;
    int n_granted;
    int n_full;
    int n_matched;
    int n_released;
    int n_released_hit;
    int n_refused;

    outstanding_request_tracker #(
        .SLOTS (SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ort_checker #(
        .SLOTS (SLOTS)
    ) scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatches     (mismatches),
        .outstanding    (pending),
        .n_granted      (n_granted),
        .n_full         (n_full),
        .n_matched      (n_matched),
        .n_released     (n_released),
        .n_released_hit (n_released_hit),
        .n_refused      (n_refused)
    );

    // Stimulus-side view of the table, learned from the response words.
    // It lags the block by a word or two; that only makes some words miss,
    // which is noise the block must handle anyway.
    bit    owned      [SLOTS];
    bit    seen       [SLOTS];   // slot has been granted at least once
    word_t owned_word [SLOTS];
    word_t sent_q[$];

    int words_sent;
    int burst_left;
    bit hold_pending;
    int holds_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Pair each response word with the request word that caused it and keep
    // the view of granted slots current, so matches and releases can aim at
    // live slots with the right fields.
    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready && sent_q.size() > 0)
        begin
            w = sent_q.pop_front();
            if (!rsp_ch.status)
            begin
                if (w.kind == OP_ALLOC)
                begin
                    owned[rsp_ch.slot_out]      = 1'b1;
                    seen[rsp_ch.slot_out]       = 1'b1;
                    owned_word[rsp_ch.slot_out] = w;
                end
                else if (w.kind == OP_RELEASE)
                begin
                    owned[rsp_ch.slot_out] = 1'b0;
                end
            end
        end
    end

    // Offer one word and return at the edge where it is taken. The sender
    // runs in bursts; at the end of each burst it drops valid for a while.
    task automatic send_word(word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            // mostly short bursts, now and then a long run with no idling
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= w.kind;
        req_ch.slot          <= w.slot;
        req_ch.net_fn        <= w.net_fn;
        req_ch.requester_lun <= w.rq_lun;
        req_ch.responder_lun <= w.rs_lun;
        req_ch.command       <= w.command;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        sent_q.push_back(w);
        words_sent++;
        burst_left--;
    endtask

    function automatic word_t mk(logic [OP_W-1:0] kind, int s, int nf, int rq, int rs, int cmd);
        word_t w;
        w.kind    = kind;
        w.slot    = SLOT_W'(s);
        w.net_fn  = NF_W'(nf);
        w.rq_lun  = LUN_W'(rq);
        w.rs_lun  = LUN_W'(rs);
        w.command = CMD_W'(cmd);
        return w;
    endfunction

    // Random pick among live slots, or among slots that were ever granted.
    function automatic logic pick_slot(logic need_live, output logic [SLOT_W-1:0] s);
        int start;
        int idx;
        start = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < SLOTS; i++)
        begin
            idx = (start + i) % SLOTS;
            if (need_live ? owned[idx] : seen[idx])
            begin
                s = SLOT_W'(idx);
                return 1'b1;
            end
        end
        s = '0;
        return 1'b0;
    endfunction

    // One random word. Most matches are proper responses to a live request
    // (netFn plus one, same LUNs and command); a few carry one flipped bit.
    // A match never aims at a slot that was never granted, since its fields
    // would be unwritten.
    function automatic word_t random_word(traffic_t mix);
        word_t             w;
        int                roll;
        int                p_alloc;
        int                p_match;
        int                p_release;
        logic [SLOT_W-1:0] s;
        w.kind    = OP_ALLOC;
        w.slot    = SLOT_W'($urandom);
        w.net_fn  = NF_W'($urandom);
        w.rq_lun  = LUN_W'($urandom);
        w.rs_lun  = LUN_W'($urandom);
        w.command = CMD_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            w.net_fn = '1;
        case (mix)
            MIX_FILL:
            begin
                p_alloc   = 70;
                p_match   = 85;
                p_release = 95;
            end
            MIX_DRAIN:
            begin
                p_alloc   = 15;
                p_match   = 45;
                p_release = 95;
            end
            default:
            begin
                p_alloc   = 35;
                p_match   = 65;
                p_release = 95;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < p_alloc)
        begin
            w.kind = OP_ALLOC;
        end
        else if (roll < p_match)
        begin
            if (pick_slot(1'b1, s) && $urandom_range(0, 99) < 85)
            begin
                w        = owned_word[s];
                w.kind   = OP_MATCH;
                w.slot   = s;
                w.net_fn = w.net_fn + 1'b1;
                if ($urandom_range(0, 6) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       w.net_fn[$urandom_range(0, NF_W - 1)]   ^= 1'b1;
                        1:       w.rq_lun[$urandom_range(0, LUN_W - 1)]  ^= 1'b1;
                        2:       w.rs_lun[$urandom_range(0, LUN_W - 1)]  ^= 1'b1;
                        default: w.command[$urandom_range(0, CMD_W - 1)] ^= 1'b1;
                    endcase
                end
            end
            else if (pick_slot(1'b0, s))
            begin
                w.kind = OP_MATCH;
                w.slot = s;
            end
        end
        else if (roll < p_release)
        begin
            w.kind = OP_RELEASE;
            if (pick_slot(1'b1, s) && $urandom_range(0, 99) < 85)
                w.slot = s;
        end
        else
        begin
            w.kind = OP_UNKNOWN;
        end
        return w;
    endfunction

    // Receiver: ready follows a style picked anew for each random-length phase
    // (always ready, coin flip, mostly stalled, periodic). Once, on request,
    // it holds off for a long stretch so the block backs up into its input.
    initial
    begin
        int style;
        int phase_len;
        int period;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            style     = $urandom_range(0, 3);
            phase_len = $urandom_range(10, 150);
            period    = $urandom_range(2, 5);
            for (int c = 0; c < phase_len; c++)
            begin
                @(posedge clk);
                if (hold_pending)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_pending = 1'b0;
                    holds_done++;
                end
                case (style)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ((c % period) != 0);
                endcase
            end
        end
    end

    // Watchdog: any handshake on either channel restarts the count.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles, %0d words still expected",
                         quiet, pending);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        traffic_t mix;
        int       seg_left;
        rst_n                = 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= OP_ALLOC;
        req_ch.slot          <= '0;
        req_ch.net_fn        <= '0;
        req_ch.requester_lun <= '0;
        req_ch.responder_lun <= '0;
        req_ch.command       <= '0;
        words_sent   = 0;
        burst_left   = 0;
        hold_pending = 1'b0;
        holds_done   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. After reset the last grant is slot 0, so the first
        // three allocates land in slots 1, 2 and 3.
        send_word(mk(OP_RELEASE, 0, 0, 0, 0, 0));            // release on an empty table
        send_word(mk(OP_UNKNOWN, 63, 63, 3, 3, 255));        // undefined operation
        send_word(mk(OP_ALLOC, 0, 0, 0, 0, 0));              // all-zero request -> 1
        send_word(mk(OP_ALLOC, 63, 63, 3, 3, 255));          // netFn 63, all ones -> 2
        send_word(mk(OP_ALLOC, 0, 6, 2, 1, 8'h37));          // -> 3
        send_word(mk(OP_MATCH, 1, 1, 0, 0, 0));              // proper response
        send_word(mk(OP_MATCH, 1, 1, 0, 0, 0));              // same response again still hits
        send_word(mk(OP_MATCH, 2, 0, 3, 3, 255));            // 63 + 1 does not wrap to 0
        send_word(mk(OP_MATCH, 2, 63, 3, 3, 255));           // equal netFn is not a response
        send_word(mk(OP_MATCH, 3, 7, 2, 1, 8'h37));          // proper response
        send_word(mk(OP_MATCH, 3, 7, 1, 1, 8'h37));          // requester LUN differs
        send_word(mk(OP_MATCH, 3, 7, 2, 2, 8'h37));          // responder LUN differs
        send_word(mk(OP_MATCH, 3, 7, 2, 1, 8'h36));          // command differs
        send_word(mk(OP_MATCH, 3, 6, 2, 1, 8'h37));          // netFn not advanced
        send_word(mk(OP_RELEASE, 1, 0, 0, 0, 0));            // release after a match
        send_word(mk(OP_RELEASE, 1, 0, 0, 0, 0));            // already free
        send_word(mk(OP_MATCH, 1, 1, 0, 0, 0));              // match on a freed slot
        send_word(mk(OP_RELEASE, 2, 0, 0, 0, 0));            // release with no match
        send_word(mk(OP_RELEASE, 63, 0, 0, 0, 0));           // top slot, never granted
        send_word(mk(OP_ALLOC, 0, 1, 1, 2, 8'h80));          // skips free slots 1, 2 -> 4
        send_word(mk(OP_RELEASE, 3, 0, 0, 0, 0));
        send_word(mk(OP_RELEASE, 4, 0, 0, 0, 0));

        // Random part. The first segment is allocate-heavy and long enough to
        // fill the table, so full-table refusals and the wrap of the
        // round-robin pointer show up early; later segments alternate.
        mix      = MIX_FILL;
        seg_left = 160;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (seg_left == 0)
            begin
                mix      = traffic_t'($urandom_range(0, 2));
                seg_left = $urandom_range(40, 160);
            end
            if (n == HOLD_AT)
                hold_pending = 1'b1;
            send_word(random_word(mix));
            seg_left--;
        end
        req_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("run covered %0d request words: %0d grants, %0d allocates refused on a full table",
                 words_sent, n_granted, n_full);
        $display("%0d matches, %0d releases (%0d after a match), %0d refused, %0d long hold-offs",
                 n_matched, n_released, n_released_hit, n_refused, holds_done);
        if (mismatches == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
